[hw/rtl/eiba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package eiba_pkg;

  localparam int unsigned MaxIds   = 1024;
  localparam int unsigned IdW      = 11;
  localparam int unsigned HighW    = 10;
  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = MaxIds / WordW;
  localparam int unsigned WidxW    = $clog2(NumWords);
  localparam int unsigned BitW     = $clog2(WordW);
  // word index with one extra bit, so that an ID of MaxIds has a word number too
  localparam int unsigned GwW      = IdW - BitW;

  typedef logic [IdW-1:0]   id_t;
  typedef logic [HighW-1:0] high_t;
  typedef logic [WordW-1:0] word_t;
  typedef logic [WidxW-1:0] widx_t;
  typedef logic [BitW-1:0]  bidx_t;
  typedef logic [GwW-1:0]   gw_t;

  localparam id_t ReservedReset = id_t'(1015);
  localparam id_t IdNone        = id_t'(MaxIds);
  localparam id_t IdLast        = id_t'(MaxIds - 1);

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2,
    OP_FLUSH   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_BAD_HINT  = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_CREATE,
    PH_DESTROY,
    PH_QUERY,
    PH_UP,
    PH_DOWN
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD,
    ST_EV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic   accept;
    logic   dispatch;
    logic   start;
    logic   eval;
    logic   load_out;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic id_ok;
    logic done;
    logic fail;
    logic need_up;
    logic need_down;
  } dp_status_t;

  function automatic bidx_t first_set(word_t v);
    bidx_t r;
    r = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) r = bidx_t'(i);
    end
    return r;
  endfunction

  function automatic bidx_t last_set(word_t v);
    bidx_t r;
    r = '0;
    for (int i = 0; i < WordW; i++) begin
      if (v[i]) r = bidx_t'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/eiba_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface eiba_in_if import eiba_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] operation;
  id_t  entity_id;
  modport source (output valid, output operation, output entity_id, input ready);
  modport sink (input valid, input operation, input entity_id, output ready);
endinterface

interface eiba_out_if import eiba_pkg::*; ();
  logic  valid;
  logic  ready;
  id_t   result_id;
  logic [1:0] status;
  logic  exists;
  id_t   lowest_taken;
  high_t highest_taken;
  modport source (output valid, output result_id, output status, output exists,
                  output lowest_taken, output highest_taken, input ready);
  modport sink (input valid, input result_id, input status, input exists,
                input lowest_taken, input highest_taken, output ready);
endinterface

interface eiba_cfg_if import eiba_pkg::*; ();
  logic valid;
  logic ready;
  id_t  reserved_start;
  modport source (output valid, output reserved_start, input ready);
  modport sink (input valid, input reserved_start, output ready);
endinterface

`default_nettype wire

[hw/rtl/eiba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module eiba_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/eiba_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module eiba_ctrl import eiba_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t dp_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_CREATE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.phase = phase_q;
    in_ready_o  = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        state_d        = ST_FIN;
        unique case (dp_i.op)
          OP_CREATE: begin
            phase_d = PH_CREATE;
            if (dp_i.id_ok) state_d = ST_RD;
          end
          OP_DESTROY: begin
            phase_d = PH_DESTROY;
            if (dp_i.id_ok) state_d = ST_RD;
          end
          OP_QUERY: begin
            phase_d = PH_QUERY;
            if (dp_i.id_ok) state_d = ST_RD;
          end
          OP_FLUSH: begin
            state_d = ST_FIN;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_RD: begin
        cmd_o.start = 1'b1;
        state_d     = ST_EV;
      end
      ST_EV: begin
        cmd_o.eval = 1'b1;
        if (dp_i.done) begin
          state_d = ST_FIN;
          priority if (phase_q == PH_DESTROY && !dp_i.fail && dp_i.need_up) begin
            phase_d = PH_UP;
            state_d = ST_RD;
          end else if ((phase_q == PH_DESTROY && !dp_i.fail || phase_q == PH_UP)
                       && dp_i.need_down) begin
            phase_d = PH_DOWN;
            state_d = ST_RD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/eiba_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module eiba_dpath import eiba_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  output dp_status_t      dp_o,
  input  wire logic [1:0] in_operation_i,
  input  wire id_t        in_entity_id_i,
  input  wire logic       cfg_valid_i,
  input  wire id_t        cfg_data_i,
  output id_t             out_result_id_o,
  output logic [1:0]      out_status_o,
  output logic            out_exists_o,
  output id_t             out_lowest_o,
  output high_t           out_highest_o
);

  op_e     op_q;
  id_t     id_q;
  id_t     reserved_q;
  id_t     lowest_q, lowest_d;
  high_t   highest_q, highest_d;
  id_t     lo_q, lo_d, hi_q, hi_d;
  logic    empty_q, empty_d;
  widx_t   widx_q, widx_d;
  logic [NumWords-1:0] valid_q, valid_d;
  id_t     res_id_q, res_id_d;
  status_e status_q, status_d;
  logic    exists_q, exists_d;
  id_t     out_res_q, out_low_q;
  status_e out_stat_q;
  logic    out_ex_q;
  high_t   out_high_q;

  word_t   rdata, word, mask, cand, wdata;
  logic    we, done, fail, found, bit_v, at_last;
  bidx_t   sel;
  gw_t     gw, lo_w, hi_w;
  id_t     g;

  eiba_ram #(.Width(WordW), .Depth(NumWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (widx_q),
    .wdata_i (wdata),
    .raddr_i (widx_d),
    .rdata_o (rdata)
  );

  assign word = valid_q[widx_q] ? rdata : '0;
  assign gw   = {1'b0, widx_q};
  assign lo_w = lo_q[IdW-1:BitW];
  assign hi_w = hi_q[IdW-1:BitW];

  always_comb begin
    for (int b = 0; b < WordW; b++) begin
      mask[b] = ((gw > lo_w) || (gw == lo_w && bidx_t'(b) >= lo_q[BitW-1:0])) &&
                ((gw < hi_w) || (gw == hi_w && bidx_t'(b) <= hi_q[BitW-1:0]));
    end
  end

  assign cand  = (cmd_i.phase == PH_CREATE) ? (~word & mask) : (word & mask);
  assign found = |cand;
  assign sel   = (cmd_i.phase == PH_DOWN) ? last_set(cand) : first_set(cand);
  assign g     = {1'b0, widx_q, sel};
  assign bit_v = word[id_q[BitW-1:0]];
  assign at_last = (cmd_i.phase == PH_DOWN) ? (gw == lo_w) : (gw == hi_w);

  always_comb begin
    lowest_d  = lowest_q;
    highest_d = highest_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    empty_d   = empty_q;
    widx_d    = widx_q;
    valid_d   = valid_q;
    res_id_d  = res_id_q;
    status_d  = status_q;
    exists_d  = exists_q;
    we        = 1'b0;
    wdata     = word;
    done      = 1'b0;
    fail      = 1'b0;

    if (cmd_i.accept) begin
      res_id_d = in_entity_id_i;
      status_d = STAT_OK;
      exists_d = 1'b0;
    end

    if (cmd_i.dispatch) begin
      unique case (op_q)
        OP_CREATE: begin
          if (id_q >= IdNone) begin
            status_d = STAT_BAD_HINT;
            res_id_d = IdNone;
          end
        end
        OP_DESTROY: begin
          if (id_q >= IdNone) status_d = STAT_NOT_FOUND;
        end
        OP_FLUSH: begin
          valid_d   = '0;
          lowest_d  = IdNone;
          highest_d = '0;
        end
        default: ;
      endcase
    end

    if (cmd_i.start) begin
      empty_d = 1'b0;
      unique case (cmd_i.phase)
        PH_CREATE: begin
          lo_d = id_q;
          hi_d = IdLast;
        end
        PH_UP: begin
          lo_d    = lowest_q + id_t'(1);
          hi_d    = {1'b0, highest_q};
          empty_d = (lo_d > hi_d);
        end
        PH_DOWN: begin
          lo_d    = lowest_q;
          hi_d    = {1'b0, highest_q} - id_t'(1);
          empty_d = (highest_q == '0) || (lo_d > hi_d);
        end
        default: begin
          lo_d = id_q;
          hi_d = id_q;
        end
      endcase
      widx_d = (cmd_i.phase == PH_DOWN) ? hi_d[BitW+WidxW-1:BitW]
                                        : lo_d[BitW+WidxW-1:BitW];
    end

    if (cmd_i.eval) begin
      unique case (cmd_i.phase)
        PH_CREATE: begin
          if (found) begin
            done  = 1'b1;
            we    = 1'b1;
            wdata = word | (word_t'(1) << sel);
            valid_d[widx_q] = 1'b1;
            res_id_d = g;
            if (g < reserved_q) begin
              if (g < lowest_q) lowest_d = g;
              if (g > {1'b0, highest_q}) highest_d = g[HighW-1:0];
            end
          end else if (at_last) begin
            done     = 1'b1;
            status_d = STAT_NO_FREE;
            res_id_d = IdNone;
          end else begin
            widx_d = widx_q + widx_t'(1);
          end
        end
        PH_DESTROY: begin
          done = 1'b1;
          if (bit_v) begin
            we    = 1'b1;
            wdata = word & ~(word_t'(1) << id_q[BitW-1:0]);
            valid_d[widx_q] = 1'b1;
          end else begin
            fail     = 1'b1;
            status_d = STAT_NOT_FOUND;
          end
        end
        PH_QUERY: begin
          done     = 1'b1;
          exists_d = bit_v;
        end
        PH_UP: begin
          if (empty_q || (!found && at_last)) begin
            done     = 1'b1;
            lowest_d = IdNone;
          end else if (found) begin
            done     = 1'b1;
            lowest_d = g;
          end else begin
            widx_d = widx_q + widx_t'(1);
          end
        end
        PH_DOWN: begin
          if (empty_q || (!found && at_last)) begin
            done      = 1'b1;
            highest_d = '0;
          end else if (found) begin
            done      = 1'b1;
            highest_d = g[HighW-1:0];
          end else begin
            widx_d = widx_q - widx_t'(1);
          end
        end
        default: done = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= ReservedReset;
      lowest_q   <= IdNone;
      highest_q  <= '0;
      valid_q    <= '0;
      widx_q     <= '0;
    end else begin
      if (cfg_valid_i) reserved_q <= cfg_data_i;
      lowest_q  <= lowest_d;
      highest_q <= highest_d;
      valid_q   <= valid_d;
      widx_q    <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= op_e'(in_operation_i);
      id_q <= in_entity_id_i;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    empty_q  <= empty_d;
    res_id_q <= res_id_d;
    status_q <= status_d;
    exists_q <= exists_d;
    if (cmd_i.load_out) begin
      out_res_q  <= res_id_q;
      out_stat_q <= status_q;
      out_ex_q   <= exists_q;
      out_low_q  <= lowest_q;
      out_high_q <= highest_q;
    end
  end

  assign dp_o.op        = op_q;
  assign dp_o.id_ok     = (id_q < IdNone);
  assign dp_o.done      = done;
  assign dp_o.fail      = fail;
  assign dp_o.need_up   = (id_q < reserved_q) && (id_q == lowest_q);
  assign dp_o.need_down = (id_q < reserved_q) && (id_q == {1'b0, highest_q});

  assign out_result_id_o = out_res_q;
  assign out_status_o    = out_stat_q;
  assign out_exists_o    = out_ex_q;
  assign out_lowest_o    = out_low_q;
  assign out_highest_o   = out_high_q;

endmodule

`default_nettype wire

[hw/rtl/entity_id_bitmap_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// First-fit ID allocator over a 1024-entry taken bitmap, stored as sixteen 64-bit words.
// in_if: one transfer carries an operation (create, destroy, query, flush) and an ID.
// out_if: one result transfer per input transfer: result ID, status, exists flag and
//   the lowest / highest taken non-reserved IDs after the operation.
// cfg_if: writes reserved_start; always ready, write it only while the block is idle.
// One item is in work at a time. Flush and out-of-range IDs skip the bitmap,
//   query and destroy read one word, and create scans up to 16 words upward from the
//   word of the hint. A destroy that removes a bound adds a rescan per bound. The
//   upward rescan ends where the downward one stops, so both together read at most
//   17 words. Scans are paced by the single bitmap RAM read port: one word per cycle.
// Reset clears the bitmap at once through per-word valid bits, sets the bounds to
//   empty and reserved_start to 1015. A flush does the same to the bitmap and bounds.
// When the receiver stalls, the result is held in the output register and the next
//   input is still taken; its result waits until the held one is transferred.

module entity_id_bitmap_allocator import eiba_pkg::*; (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  eiba_in_if.sink    in_if,
  eiba_out_if.source out_if,
  eiba_cfg_if.sink   cfg_if
);

  cmd_t       cmd;
  dp_status_t dp_status;

  // configuration writes are taken in any cycle
  assign cfg_if.ready = 1'b1;

  eiba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .dp_i        (dp_status),
    .cmd_o       (cmd)
  );

  eiba_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .dp_o            (dp_status),
    .in_operation_i  (in_if.operation),
    .in_entity_id_i  (in_if.entity_id),
    .cfg_valid_i     (cfg_if.valid),
    .cfg_data_i      (cfg_if.reserved_start),
    .out_result_id_o (out_if.result_id),
    .out_status_o    (out_if.status),
    .out_exists_o    (out_if.exists),
    .out_lowest_o    (out_if.lowest_taken),
    .out_highest_o   (out_if.highest_taken)
  );

  // one item at a time: after a transfer in, no new transfer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input taken while an item is in work");

  // a failed create reports no ID
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (out_if.status == STAT_NO_FREE || out_if.status == STAT_BAD_HINT))
    |-> (out_if.result_id == IdNone))
    else $error("failed create with an ID");

  // exists is only reported with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.exists) |-> (out_if.status == STAT_OK))
    else $error("exists flag with error status");

endmodule

`default_nettype wire

[tb/entity_id_bitmap_allocator_tb.sv]
`timescale 1ns / 1ps

module entity_id_bitmap_allocator_tb;
  import eiba_pkg::*;

  logic clk_i;
  logic rst_ni;

  eiba_in_if  in_if ();
  eiba_out_if out_if ();
  eiba_cfg_if cfg_if ();

  entity_id_bitmap_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // Expected result of one transfer.
  typedef struct {
    id_t     result_id;
    status_e status;
    logic    exists;
    id_t     lowest_taken;
    high_t   highest_taken;
  } alloc_result_t;

  // Shadow state of the allocator.
  logic       shadow_map [MaxIds];
  int unsigned shadow_low;
  int unsigned shadow_high;
  int unsigned shadow_reserved;

  alloc_result_t pending_results [$];
  int          fail_count;
  // The no-idle stretch turns off random gaps on both sides.
  bit          steady_mode;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop; far above the slowest run of all items.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void shadow_clear();
    foreach (shadow_map[i]) shadow_map[i] = 1'b0;
    shadow_low  = MaxIds;
    shadow_high = 0;
  endfunction

  // Fix the bounds after a destroy: lowest first, then highest, the downward scan
  // stopping at the new lowest bound.
  function automatic void shadow_repair(int unsigned id);
    int unsigned i;
    int unsigned nl;
    int unsigned nh;
    if (id == shadow_low) begin
      nl = MaxIds;
      for (i = shadow_low + 1; i <= shadow_high && i < MaxIds; i++) begin
        if (shadow_map[i]) begin
          nl = i;
          break;
        end
      end
      shadow_low = nl;
    end
    if (id == shadow_high) begin
      nh = 0;
      i = shadow_high;
      while (i > 0) begin
        i--;
        if (i < shadow_low) break;
        if (shadow_map[i]) begin
          nh = i;
          break;
        end
      end
      shadow_high = nh;
    end
  endfunction

  // Apply one operation to the shadow state and return its result.
  function automatic alloc_result_t predict_alloc(op_e op, id_t id);
    alloc_result_t r;
    int unsigned i;
    r.result_id = id;
    r.status    = STAT_OK;
    r.exists    = 1'b0;
    case (op)
      OP_CREATE: begin
        if (id >= MaxIds) begin
          r.status = STAT_BAD_HINT;
          r.result_id = IdNone;
        end else begin
          i = id;
          while (i < MaxIds && shadow_map[i]) i++;
          if (i >= MaxIds) begin
            r.status = STAT_NO_FREE;
            r.result_id = IdNone;
          end else begin
            shadow_map[i] = 1'b1;
            if (i < shadow_reserved) begin
              if (i < shadow_low) shadow_low = i;
              if (i > shadow_high) shadow_high = i;
            end
            r.result_id = id_t'(i);
          end
        end
      end
      OP_DESTROY: begin
        if (id >= MaxIds || !shadow_map[id]) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          shadow_map[id] = 1'b0;
          if (id < shadow_reserved) shadow_repair(id);
        end
      end
      OP_QUERY: begin
        r.exists = (id < MaxIds) && shadow_map[id];
      end
      default: begin
        shadow_clear();
      end
    endcase
    r.lowest_taken  = id_t'(shadow_low);
    r.highest_taken = high_t'(shadow_high);
    return r;
  endfunction

  function automatic bit gap_now();
    return !steady_mode && ($urandom_range(99) < 14);
  endfunction

  // Send one operation; predict at the accepting edge.
  task automatic send_op(op_e op, id_t id);
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.entity_id <= id;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_alloc(op, id));
    if (gap_now()) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for all results, then let a late rescan settle before touching config.
  task automatic wait_idle();
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reserved(id_t value);
    wait_idle();
    cfg_if.valid          <= 1'b1;
    cfg_if.reserved_start <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    shadow_reserved = value;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stall, compare every transfer with the oldest expectation.
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result_id: unexpected transfer, actual %0d", out_if.result_id);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_if.result_id !== exp_r.result_id) begin
            $error("result_id: expected %0d actual %0d", exp_r.result_id, out_if.result_id);
            fail_count++;
          end
          if (out_if.status !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, out_if.status);
            fail_count++;
          end
          if (out_if.exists !== exp_r.exists) begin
            $error("exists: expected %0d actual %0d", exp_r.exists, out_if.exists);
            fail_count++;
          end
          if (out_if.lowest_taken !== exp_r.lowest_taken) begin
            $error("lowest_taken: expected %0d actual %0d",
                   exp_r.lowest_taken, out_if.lowest_taken);
            fail_count++;
          end
          if (out_if.highest_taken !== exp_r.highest_taken) begin
            $error("highest_taken: expected %0d actual %0d",
                   exp_r.highest_taken, out_if.highest_taken);
            fail_count++;
          end
        end
      end
      out_if.ready <= !gap_now();
    end
  end

  // Directed: extremes of the hint, every operation and every status.
  task automatic test_directed();
    send_op(OP_QUERY, id_t'(0));
    send_op(OP_DESTROY, id_t'(5));
    send_op(OP_CREATE, IdNone);
    send_op(OP_CREATE, id_t'(2047));
    send_op(OP_DESTROY, IdNone);
    send_op(OP_QUERY, id_t'(2047));
    send_op(OP_CREATE, id_t'(0));
    send_op(OP_CREATE, id_t'(0));
    send_op(OP_CREATE, IdLast);
    send_op(OP_CREATE, IdLast);
    send_op(OP_CREATE, id_t'(1015));
    send_op(OP_CREATE, id_t'(1014));
    send_op(OP_QUERY, IdLast);
    send_op(OP_DESTROY, id_t'(1014));
    send_op(OP_DESTROY, id_t'(0));
    send_op(OP_DESTROY, id_t'(1));
    send_op(OP_DESTROY, IdLast);
    send_op(OP_FLUSH, id_t'(1365));
    send_op(OP_FLUSH, id_t'(682));
  endtask

  // Fill the top of the map so create runs out of free IDs above a hint, then tear down.
  task automatic test_full_range();
    int unsigned k;
    for (k = 0; k < 16; k++) send_op(OP_CREATE, id_t'(MaxIds - 16));
    send_op(OP_CREATE, id_t'(MaxIds - 16));
    send_op(OP_CREATE, IdLast);
    for (k = 0; k < 40; k++) begin
      send_op(OP_DESTROY, id_t'($urandom_range(MaxIds - 1, MaxIds - 32)));
    end
    send_op(OP_FLUSH, id_t'(0));
  endtask

  // Random mix, around small windows unless wide, so bounds are repaired often.
  task automatic test_random(int unsigned count, bit wide);
    int unsigned k;
    int unsigned sel;
    id_t         id;
    op_e         op;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) op = OP_CREATE;
      else if (sel < 80) op = OP_DESTROY;
      else if (sel < 98) op = OP_QUERY;
      else op = OP_FLUSH;
      if (wide || $urandom_range(9) == 0) id = id_t'($urandom_range(2047));
      else id = id_t'($urandom_range(MaxIds - 1, MaxIds - 48) & (wide ? 11'h7ff : 11'h03f)
                      | ($urandom_range(1) ? 11'h3c0 : 11'h000));
      send_op(op, id);
    end
  endtask

  initial begin
    fail_count       = 0;
    steady_mode      = 1'b0;
    shadow_reserved  = ReservedReset;
    shadow_clear();
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_QUERY;
    in_if.entity_id  = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reserved_start = ReservedReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_reserved(id_t'(0));
    test_random(150, 1'b0);
    write_reserved(id_t'(1024));
    test_random(150, 1'b0);
    write_reserved(id_t'(1000));
    test_random(150, 1'b0);
    write_reserved(id_t'(30));
    test_random(150, 1'b0);
    steady_mode = 1'b1;
    test_random(150, 1'b1);
    steady_mode = 1'b0;
    write_reserved(id_t'($urandom_range(1024)));
    test_random(150, 1'b0);
    test_full_range();

    wait_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
